// ----- src/tds_pkg.sv -----
// Shared codes, command set and status bundle for the task dependency scheduler.
`timescale 1ns / 1ps
package tds_pkg;

  // Width of slot fields on the stream ports and of the pending counters
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned PEND_W   = 7;
  localparam logic [PEND_W-1:0] PEND_MAX = 7'd127;

  // Input item kinds
  localparam logic [1:0] KIND_CREATE   = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_TAKE     = 2'd3;

  // Result kinds
  localparam logic [2:0] RES_CREATED    = 3'd0;
  localparam logic [2:0] RES_DISPATCHED = 3'd1;
  localparam logic [2:0] RES_TAKEN      = 3'd2;
  localparam logic [2:0] RES_PENDING    = 3'd3;
  localparam logic [2:0] RES_FREED      = 3'd4;

  // Slot phases
  localparam logic [1:0] PH_FREE    = 2'd0;
  localparam logic [1:0] PH_CREATED = 2'd1;
  localparam logic [1:0] PH_QUEUED  = 2'd2;
  localparam logic [1:0] PH_TAKEN   = 2'd3;

  // Dependency flag bits
  localparam logic [1:0] FL_DISP = 2'b01;
  localparam logic [1:0] FL_DEP  = 2'b10;
  localparam logic [1:0] FL_BOTH = 2'b11;

  // Datapath commands issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_RD_FH,
    OP_RD_PAR,
    OP_CR_PAR,
    OP_RD_DEP,
    OP_CR_DEP,
    OP_RD_TAIL,
    OP_CR_TAIL,
    OP_CR_FIN,
    OP_RD_TS,
    OP_DISP,
    OP_TAKE0,
    OP_TAKE1,
    OP_TAKE2,
    OP_K_CHECK,
    OP_RD_CUR,
    OP_W_DEC,
    OP_RD_D,
    OP_R_STEP,
    OP_FREE,
    OP_RD_LINK,
    OP_F_EMIT
  } op_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [1:0] kind_in;
    logic       out_free;
    logic       full;
    logic       take_empty;
    logic       k_bad;
    logic       w_stop;
    logic       rel_done;
    logic       chain_end;
    logic       init_last;
  } st_t;

endpackage

// ----- src/tds_ctrl.sv -----
// Sequencer that steps the scheduler datapath through each item's command list.
`timescale 1ns / 1ps
module tds_ctrl
  import tds_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  st_t  st_i,
  output op_e  op_o
);

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_CR0, ST_CR1, ST_CR2, ST_CR3, ST_CR4, ST_CR5, ST_CR6, ST_CR7,
    ST_DS0, ST_DS1,
    ST_TK0, ST_TK1, ST_TK2,
    ST_KC0, ST_KC1,
    ST_WA, ST_WB, ST_RA, ST_RB, ST_FR, ST_FA, ST_FB
  } state_e;

  state_e state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Pick the command and the next step
  always_comb begin
    op_o    = OP_NONE;
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        op_o = OP_INIT;
        if (st_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_o = OP_LOAD;
          unique case (st_i.kind_in)
            KIND_CREATE:   state_d = ST_CR0;
            KIND_DISPATCH: state_d = ST_DS0;
            KIND_COMPLETE: state_d = ST_KC0;
            KIND_TAKE:     state_d = ST_TK0;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_CR0: begin
        if (st_i.out_free) begin
          op_o    = OP_RD_FH;
          state_d = st_i.full ? ST_IDLE : ST_CR1;
        end
      end
      ST_CR1: begin op_o = OP_RD_PAR;  state_d = ST_CR2; end
      ST_CR2: begin op_o = OP_CR_PAR;  state_d = ST_CR3; end
      ST_CR3: begin op_o = OP_RD_DEP;  state_d = ST_CR4; end
      ST_CR4: begin op_o = OP_CR_DEP;  state_d = ST_CR5; end
      ST_CR5: begin op_o = OP_RD_TAIL; state_d = ST_CR6; end
      ST_CR6: begin op_o = OP_CR_TAIL; state_d = ST_CR7; end
      ST_CR7: begin
        if (st_i.out_free) begin
          op_o    = OP_CR_FIN;
          state_d = ST_IDLE;
        end
      end
      ST_DS0: begin op_o = OP_RD_TS; state_d = ST_DS1; end
      ST_DS1: begin
        if (st_i.out_free) begin
          op_o    = OP_DISP;
          state_d = ST_IDLE;
        end
      end
      ST_TK0: begin
        if (st_i.out_free) begin
          op_o    = OP_TAKE0;
          state_d = st_i.take_empty ? ST_IDLE : ST_TK1;
        end
      end
      ST_TK1: begin op_o = OP_TAKE1; state_d = ST_TK2; end
      ST_TK2: begin
        if (st_i.out_free) begin
          op_o    = OP_TAKE2;
          state_d = ST_IDLE;
        end
      end
      ST_KC0: begin op_o = OP_RD_TS; state_d = ST_KC1; end
      ST_KC1: begin
        if (st_i.out_free) begin
          op_o    = OP_K_CHECK;
          state_d = st_i.k_bad ? ST_IDLE : ST_WA;
        end
      end
      ST_WA: begin op_o = OP_RD_CUR; state_d = ST_WB; end
      ST_WB: begin
        if (st_i.out_free) begin
          op_o    = OP_W_DEC;
          state_d = st_i.w_stop ? ST_IDLE : ST_RA;
        end
      end
      ST_RA: begin
        if (st_i.rel_done) begin
          state_d = ST_FR;
        end else begin
          op_o    = OP_RD_D;
          state_d = ST_RB;
        end
      end
      ST_RB: begin op_o = OP_R_STEP;  state_d = ST_RA; end
      ST_FR: begin op_o = OP_FREE;    state_d = ST_FA; end
      ST_FA: begin op_o = OP_RD_LINK; state_d = ST_FB; end
      ST_FB: begin
        if (st_i.out_free) begin
          op_o    = OP_F_EMIT;
          state_d = st_i.chain_end ? ST_IDLE : ST_WA;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/tds_datapath.sv -----
// Slot table, ready queues, walk registers and result register of the scheduler.
`timescale 1ns / 1ps
module tds_datapath
  import tds_pkg::*;
#(
  parameter int unsigned TASK_SLOTS      = 64,
  parameter int unsigned PRIORITY_LEVELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  op_e         op_i,
  output st_t         st_o,
  input  logic [23:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned SW    = $clog2(TASK_SLOTS);
  localparam int unsigned LW    = $clog2(TASK_SLOTS + 1);
  localparam int unsigned LVW   = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int unsigned FDEP  = PRIORITY_LEVELS * TASK_SLOTS;
  localparam int unsigned FAW   = $clog2(FDEP);
  localparam logic [LW-1:0] NONE = LW'(TASK_SLOTS);
  localparam logic [1:0] PR_TOP = 2'(PRIORITY_LEVELS - 1);

  typedef struct packed {
    logic [1:0]        phase;
    logic [1:0]        flags;
    logic [PEND_W-1:0] pend;
    logic [LW-1:0]     parent;
    logic [LW-1:0]     head;
    logic [LW-1:0]     tail;
    logic [LW-1:0]     nxt;
    logic [1:0]        prio;
    logic              work;
    logic              waiter;
    logic [LW-1:0]     fnext;
  } rec_t;

  // Slot table and ready queues
  rec_t           tbl_mem [TASK_SLOTS];
  rec_t           rd_q;
  logic [SW-1:0]  fifo_mem [FDEP];
  logic [SW-1:0]  fifo_rd_q;

  logic           re, we, fifo_re, fifo_we;
  logic [SW-1:0]  raddr, waddr, fifo_wdata;
  logic [FAW-1:0] fifo_raddr, fifo_waddr;
  rec_t           wrec;

  // Item registers
  logic [1:0]        kind_q, kind_d;
  logic [SLOT_W-1:0] ts_q, ts_d, par_in_q, par_in_d, dep_in_q, dep_in_d;
  logic [1:0]        prio_q, prio_d;
  logic              hp_q, hp_d, hd_q, hd_d, work_q, work_d, waiter_q, waiter_d;

  // Work registers
  logic [SW-1:0] s_q, s_d, cur_q, cur_d, init_q, init_d;
  logic [LW-1:0] fnext_q, fnext_d, tail_q, tail_d, link_q, link_d;
  logic [LW-1:0] d_q, d_d, steps_q, steps_d, free_head_q, free_head_d;
  logic          par_ok_q, par_ok_d, append_q, append_d;
  rec_t          cur_rec_q, cur_rec_d;

  logic [SW-1:0] rptr_q [PRIORITY_LEVELS];
  logic [SW-1:0] rptr_d [PRIORITY_LEVELS];
  logic [SW-1:0] wptr_q [PRIORITY_LEVELS];
  logic [SW-1:0] wptr_d [PRIORITY_LEVELS];
  logic [LW-1:0] fill_q [PRIORITY_LEVELS];
  logic [LW-1:0] fill_d [PRIORITY_LEVELS];

  // Result register
  logic       o_valid_q;
  logic [2:0] o_kind_q;
  logic [5:0] o_slot_q;
  logic       o_ok_q, o_work_q, o_notify_q, o_last_q;
  logic       emit, e_ok, e_work, e_notify, e_last;
  logic [2:0] e_kind;
  logic [5:0] e_slot;

  logic           out_free, ts_ok, par_ok, dep_ok, take_found, enq_req, enq_room;
  logic [LVW-1:0] take_lvl, enq_lvl;
  logic [SW-1:0]  enq_slot;
  logic [PEND_W-1:0] pend_n;

  function automatic logic [SW-1:0] ptr_inc(logic [SW-1:0] p);
    return (p == SW'(TASK_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [FAW-1:0] fidx(logic [LVW-1:0] l, logic [SW-1:0] p);
    return FAW'(l) * FAW'(TASK_SLOTS) + FAW'(p);
  endfunction

  assign out_free = !o_valid_q || m_axis_tready;
  assign ts_ok    = ({1'b0, ts_q} < 7'(TASK_SLOTS));
  assign par_ok   = hp_q && ({1'b0, par_in_q} < 7'(TASK_SLOTS)) && (rd_q.phase != PH_FREE);
  assign dep_ok   = hd_q && ({1'b0, dep_in_q} < 7'(TASK_SLOTS)) && (rd_q.phase != PH_FREE);
  assign pend_n   = (rd_q.pend != '0) ? rd_q.pend - 1'b1 : '0;
  assign enq_lvl  = LVW'(rd_q.prio);
  assign enq_room = (fill_q[enq_lvl] != NONE);

  // Lowest non-empty priority level
  always_comb begin
    take_found = 1'b0;
    take_lvl   = '0;
    for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
      if (fill_q[l] != '0) begin
        take_found = 1'b1;
        take_lvl   = LVW'(l);
      end
    end
  end

  // Status for the controller
  always_comb begin
    st_o.kind_in    = s_axis_tuser;
    st_o.out_free   = out_free;
    st_o.full       = (free_head_q >= NONE);
    st_o.take_empty = !take_found;
    st_o.k_bad      = !ts_ok || (rd_q.phase != PH_TAKEN);
    st_o.w_stop     = (pend_n != '0);
    st_o.rel_done   = (d_q >= NONE) || (steps_q == NONE);
    st_o.chain_end  = (link_q >= NONE) || (rd_q.phase == PH_FREE);
    st_o.init_last  = (init_q == SW'(TASK_SLOTS - 1));
  end

  // Execute the current command
  always_comb begin
    re = 1'b0; we = 1'b0; raddr = '0; waddr = '0; wrec = rd_q;
    fifo_re = 1'b0; fifo_raddr = '0;
    enq_req = 1'b0; enq_slot = '0;
    emit = 1'b0; e_kind = RES_CREATED; e_slot = '0; e_ok = 1'b0;
    e_work = 1'b0; e_notify = 1'b0; e_last = 1'b1;
    kind_d = kind_q; ts_d = ts_q; par_in_d = par_in_q; dep_in_d = dep_in_q;
    prio_d = prio_q; hp_d = hp_q; hd_d = hd_q; work_d = work_q; waiter_d = waiter_q;
    s_d = s_q; cur_d = cur_q; init_d = init_q; fnext_d = fnext_q; tail_d = tail_q;
    link_d = link_q; d_d = d_q; steps_d = steps_q; free_head_d = free_head_q;
    par_ok_d = par_ok_q; append_d = append_q; cur_rec_d = cur_rec_q;
    rptr_d = rptr_q; wptr_d = wptr_q; fill_d = fill_q;
    unique case (op_i)
      OP_NONE: ;
      OP_INIT: begin
        wrec       = '0;
        wrec.phase = PH_FREE;
        wrec.fnext = LW'(init_q) + 1'b1;
        we         = 1'b1;
        waddr      = init_q;
        init_d     = init_q + 1'b1;
      end
      OP_LOAD: begin
        kind_d   = s_axis_tuser;
        ts_d     = s_axis_tdata[5:0];
        prio_d   = s_axis_tdata[7:6];
        hp_d     = s_axis_tdata[8];
        par_in_d = s_axis_tdata[14:9];
        hd_d     = s_axis_tdata[15];
        dep_in_d = s_axis_tdata[21:16];
        work_d   = s_axis_tdata[22];
        waiter_d = s_axis_tdata[23];
      end
      OP_RD_FH: begin
        if (free_head_q >= NONE) begin
          emit   = 1'b1;
          e_kind = RES_CREATED;
        end else begin
          re    = 1'b1;
          raddr = SW'(free_head_q);
          s_d   = SW'(free_head_q);
        end
      end
      OP_RD_PAR: begin
        fnext_d = rd_q.fnext;
        re      = 1'b1;
        raddr   = SW'(par_in_q);
      end
      OP_CR_PAR: begin
        par_ok_d = par_ok;
        if (par_ok) begin
          if (rd_q.pend < PEND_MAX) wrec.pend = rd_q.pend + 1'b1;
          we    = 1'b1;
          waddr = SW'(par_in_q);
        end
      end
      OP_RD_DEP: begin
        re    = 1'b1;
        raddr = SW'(dep_in_q);
      end
      OP_CR_DEP: begin
        append_d = dep_ok && (rd_q.pend != '0);
        tail_d   = rd_q.tail;
        if (dep_ok && (rd_q.pend != '0)) begin
          wrec.tail = LW'(s_q);
          if (rd_q.tail >= NONE) wrec.head = LW'(s_q);
          we    = 1'b1;
          waddr = SW'(dep_in_q);
        end
      end
      OP_RD_TAIL: begin
        re    = 1'b1;
        raddr = SW'(tail_q);
      end
      OP_CR_TAIL: begin
        if (append_q && (tail_q < NONE)) begin
          wrec.nxt = LW'(s_q);
          we       = 1'b1;
          waddr    = SW'(tail_q);
        end
      end
      OP_CR_FIN: begin
        wrec.phase  = PH_CREATED;
        wrec.flags  = append_q ? 2'b00 : FL_DEP;
        wrec.pend   = PEND_W'(1);
        wrec.parent = par_ok_q ? LW'(par_in_q) : NONE;
        wrec.head   = NONE;
        wrec.tail   = NONE;
        wrec.nxt    = NONE;
        wrec.prio   = ({2'b00, prio_q} >= 4'(PRIORITY_LEVELS)) ? PR_TOP : prio_q;
        wrec.work   = work_q;
        wrec.waiter = waiter_q;
        wrec.fnext  = fnext_q;
        we          = 1'b1;
        waddr       = s_q;
        free_head_d = fnext_q;
        emit        = 1'b1;
        e_kind      = RES_CREATED;
        e_slot      = 6'(s_q);
        e_ok        = 1'b1;
      end
      OP_RD_TS: begin
        re    = 1'b1;
        raddr = SW'(ts_q);
      end
      OP_DISP: begin
        emit   = 1'b1;
        e_kind = RES_DISPATCHED;
        e_slot = ts_q;
        if (ts_ok && (rd_q.phase == PH_CREATED) && !rd_q.flags[0]) begin
          e_ok       = 1'b1;
          wrec.flags = rd_q.flags | FL_DISP;
          if (((rd_q.flags | FL_DISP) == FL_BOTH) && enq_room) begin
            enq_req    = 1'b1;
            enq_slot   = SW'(ts_q);
            wrec.phase = PH_QUEUED;
          end
          we    = 1'b1;
          waddr = SW'(ts_q);
        end
      end
      OP_TAKE0: begin
        if (!take_found) begin
          emit   = 1'b1;
          e_kind = RES_TAKEN;
        end else begin
          fifo_re          = 1'b1;
          fifo_raddr       = fidx(take_lvl, rptr_q[take_lvl]);
          rptr_d[take_lvl] = ptr_inc(rptr_q[take_lvl]);
          fill_d[take_lvl] = fill_q[take_lvl] - 1'b1;
        end
      end
      OP_TAKE1: begin
        s_d   = fifo_rd_q;
        re    = 1'b1;
        raddr = fifo_rd_q;
      end
      OP_TAKE2: begin
        wrec.phase = PH_TAKEN;
        we         = 1'b1;
        waddr      = s_q;
        emit       = 1'b1;
        e_kind     = RES_TAKEN;
        e_slot     = 6'(s_q);
        e_ok       = 1'b1;
        e_work     = rd_q.work;
      end
      OP_K_CHECK: begin
        if (!ts_ok || (rd_q.phase != PH_TAKEN)) begin
          emit   = 1'b1;
          e_kind = RES_PENDING;
          e_slot = ts_q;
        end else begin
          cur_d = SW'(ts_q);
        end
      end
      OP_RD_CUR: begin
        re    = 1'b1;
        raddr = cur_q;
      end
      OP_W_DEC: begin
        wrec.pend = pend_n;
        we        = 1'b1;
        waddr     = cur_q;
        if (pend_n != '0) begin
          emit   = 1'b1;
          e_kind = RES_PENDING;
          e_slot = 6'(cur_q);
          e_ok   = 1'b1;
        end else begin
          cur_rec_d      = rd_q;
          cur_rec_d.pend = '0;
          link_d         = rd_q.parent;
          d_d            = rd_q.head;
          steps_d        = '0;
        end
      end
      OP_RD_D: begin
        re    = 1'b1;
        raddr = SW'(d_q);
      end
      OP_R_STEP: begin
        d_d     = rd_q.nxt;
        steps_d = steps_q + 1'b1;
        if ((rd_q.phase == PH_CREATED) && !rd_q.flags[1]) begin
          wrec.flags = rd_q.flags | FL_DEP;
          if (((rd_q.flags | FL_DEP) == FL_BOTH) && enq_room) begin
            enq_req    = 1'b1;
            enq_slot   = SW'(d_q);
            wrec.phase = PH_QUEUED;
          end
          we    = 1'b1;
          waddr = SW'(d_q);
        end
      end
      OP_FREE: begin
        wrec        = cur_rec_q;
        wrec.phase  = PH_FREE;
        wrec.flags  = 2'b00;
        wrec.fnext  = free_head_q;
        we          = 1'b1;
        waddr       = cur_q;
        free_head_d = LW'(cur_q);
      end
      OP_RD_LINK: begin
        re    = 1'b1;
        raddr = SW'(link_q);
      end
      OP_F_EMIT: begin
        emit     = 1'b1;
        e_kind   = RES_FREED;
        e_slot   = 6'(cur_q);
        e_ok     = 1'b1;
        e_notify = cur_rec_q.waiter;
        e_last   = (link_q >= NONE) || (rd_q.phase == PH_FREE);
        if (!e_last) cur_d = SW'(link_q);
      end
      default: ;
    endcase
    // Push a slot whose flags are both set into its priority queue
    fifo_we    = enq_req;
    fifo_waddr = fidx(enq_lvl, wptr_q[enq_lvl]);
    fifo_wdata = enq_slot;
    if (enq_req) begin
      wptr_d[enq_lvl] = ptr_inc(wptr_q[enq_lvl]);
      fill_d[enq_lvl] = fill_q[enq_lvl] + 1'b1;
    end
  end

  // Table and queue memories
  always_ff @(posedge clk_i) begin
    if (we) tbl_mem[waddr] <= wrec;
    if (re) rd_q <= tbl_mem[raddr];
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
    if (fifo_re) fifo_rd_q <= fifo_mem[fifo_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      free_head_q <= '0;
      o_valid_q   <= 1'b0;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        rptr_q[l] <= '0;
        wptr_q[l] <= '0;
        fill_q[l] <= '0;
      end
    end else begin
      init_q      <= init_d;
      free_head_q <= free_head_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      fill_q      <= fill_d;
      if (emit) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; ts_q <= ts_d; par_in_q <= par_in_d; dep_in_q <= dep_in_d;
    prio_q <= prio_d; hp_q <= hp_d; hd_q <= hd_d; work_q <= work_d; waiter_q <= waiter_d;
    s_q <= s_d; cur_q <= cur_d; fnext_q <= fnext_d; tail_q <= tail_d; link_q <= link_d;
    d_q <= d_d; steps_q <= steps_d; par_ok_q <= par_ok_d; append_q <= append_d;
    cur_rec_q <= cur_rec_d;
    if (emit) begin
      o_kind_q   <= e_kind;
      o_slot_q   <= e_slot;
      o_ok_q     <= e_ok;
      o_work_q   <= e_work;
      o_notify_q <= e_notify;
      o_last_q   <= e_last;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {7'd0, o_notify_q, o_work_q, o_ok_q, o_slot_q};

  // Free list head is a slot or the end marker
  a_free_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NONE) else $error("free list head out of range");

  // A new result always lands in the result register
  a_emit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> o_valid_q) else $error("result lost");

  // Lowest queue never holds more slots than exist
  a_fill0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= NONE) else $error("ready queue overfilled");

  // A result is only produced while the register can take it
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result overwrites pending transfer");

endmodule

// ----- src/task_dependency_scheduler_unit.sv -----
// Top level of the task dependency scheduler: controller plus datapath.
// Each item steps through its own command list; a stalled result output holds the item.
// After reset a clearing pass builds the free list and
// marks every slot free; no input transfer is taken until it ends.
`timescale 1ns / 1ps
module task_dependency_scheduler_unit
  import tds_pkg::*;
#(
  parameter int unsigned TASK_SLOTS      = 64,
  parameter int unsigned PRIORITY_LEVELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // task_slot[5:0], priority_req[7:6], has_parent[8], parent_slot[14:9],
  // has_dependency[15], dependency_slot[21:16], has_work[22], has_waiter[23]
  input  logic [23:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot[5:0], ok[6], has_work_res[7], notify_waiter[8], zero fill above
  output logic [15:0] m_axis_tdata,
  // result_kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  op_e op;
  st_t st;

  tds_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .st_i (st),
    .op_o (op)
  );

  tds_datapath #(
    .TASK_SLOTS      (TASK_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .op_i (op),
    .st_o (st),
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the task dependency scheduler unit.
`timescale 1ns / 1ps
module testbench;
  import tds_pkg::*;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned LEVELS = 4;
  localparam int unsigned NONE   = SLOTS;
  localparam int unsigned LIMIT  = 1000000;

  typedef struct packed {
    logic [2:0] rkind;
    logic [5:0] slot;
    logic       ok;
    logic       work;
    logic       notify;
    logic       last;
  } sched_res_t;

  // Scheduler state mirror and queue of predicted results
  class sched_board;
    logic [1:0] phase[SLOTS];
    logic [1:0] flags[SLOTS];
    int         pend[SLOTS];
    int         parent[SLOTS];
    int         dhead[SLOTS];
    int         dtail[SLOTS];
    int         dnext[SLOTS];
    int         prio[SLOTS];
    bit         work[SLOTS];
    bit         waiter[SLOTS];
    int         fnext[SLOTS];
    int         fhead;
    int         ready_q[LEVELS][$];
    sched_res_t pending_res[$];
    int         errors;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        phase[i] = PH_FREE;
        flags[i] = 2'b00;
        pend[i] = 0;
        fnext[i] = i + 1;
      end
      fhead = 0;
      for (int p = 0; p < LEVELS; p++) ready_q[p].delete();
      pending_res.delete();
      errors = 0;
    endfunction

    function void push(logic [2:0] k, int s, bit ok, bit w, bit nt);
      sched_res_t r;
      r.rkind = k;
      r.slot = s[5:0];
      r.ok = ok;
      r.work = w;
      r.notify = nt;
      r.last = 1'b0;
      pending_res.insert(pending_res.size(), r);
    endfunction

    function void set_flag(int s, logic [1:0] f);
      flags[s] |= f;
      if (flags[s] == FL_BOTH && ready_q[prio[s]].size() < SLOTS) begin
        ready_q[prio[s]].insert(ready_q[prio[s]].size(), s);
        phase[s] = PH_QUEUED;
      end
    endfunction

    function void release_deps(int s);
      int d;
      int nx;
      d = dhead[s];
      for (int k = 0; k < SLOTS && d < SLOTS; k++) begin
        nx = dnext[d];
        if (phase[d] == PH_CREATED && !flags[d][1]) set_flag(d, FL_DEP);
        d = nx;
      end
    endfunction

    // Predict the results of one accepted command
    function void note_input(logic [1:0] kind, logic [23:0] d);
      int before_n;
      int ts;
      int s;
      int par;
      int dep;
      int cur;
      bit hp;
      bit hd;
      bit found;
      before_n = pending_res.size();
      ts = d[5:0];
      case (kind)
        KIND_CREATE: begin
          s = fhead;
          par = d[14:9];
          dep = d[21:16];
          hp = d[8] && phase[par] != PH_FREE;
          hd = d[15] && phase[dep] != PH_FREE;
          if (s >= SLOTS) begin
            push(RES_CREATED, 0, 0, 0, 0);
          end else begin
            fhead = fnext[s];
            phase[s] = PH_CREATED;
            flags[s] = 2'b00;
            pend[s] = 1;
            parent[s] = hp ? par : NONE;
            dhead[s] = NONE;
            dtail[s] = NONE;
            dnext[s] = NONE;
            prio[s] = (d[7:6] >= LEVELS) ? LEVELS - 1 : d[7:6];
            work[s] = d[22];
            waiter[s] = d[23];
            if (hp && pend[par] < 127) pend[par]++;
            if (hd && pend[dep] > 0) begin
              if (dtail[dep] < SLOTS) dnext[dtail[dep]] = s;
              else dhead[dep] = s;
              dtail[dep] = s;
            end else begin
              flags[s] = FL_DEP;
            end
            push(RES_CREATED, s, 1, 0, 0);
          end
        end
        KIND_DISPATCH: begin
          if (phase[ts] == PH_CREATED && !flags[ts][0]) begin
            set_flag(ts, FL_DISP);
            push(RES_DISPATCHED, ts, 1, 0, 0);
          end else begin
            push(RES_DISPATCHED, ts, 0, 0, 0);
          end
        end
        KIND_TAKE: begin
          found = 0;
          for (int p = 0; p < LEVELS && !found; p++) begin
            if (ready_q[p].size() > 0) begin
              s = ready_q[p][0];
              ready_q[p].delete(0);
              phase[s] = PH_TAKEN;
              push(RES_TAKEN, s, 1, work[s], 0);
              found = 1;
            end
          end
          if (!found) push(RES_TAKEN, 0, 0, 0, 0);
        end
        default: begin
          if (phase[ts] != PH_TAKEN) begin
            push(RES_PENDING, ts, 0, 0, 0);
          end else begin
            cur = ts;
            // Walk up the parent chain, freeing slots whose count drops to zero
            for (int k = 0; k < SLOTS; k++) begin
              if (pend[cur] > 0) pend[cur]--;
              if (pend[cur] > 0) begin
                push(RES_PENDING, cur, 1, 0, 0);
                break;
              end
              par = parent[cur];
              release_deps(cur);
              phase[cur] = PH_FREE;
              flags[cur] = 2'b00;
              fnext[cur] = fhead;
              fhead = cur;
              push(RES_FREED, cur, 1, 0, waiter[cur]);
              if (par >= SLOTS || phase[par] == PH_FREE) break;
              cur = par;
            end
          end
        end
      endcase
      if (pending_res.size() > before_n) pending_res[$].last = 1'b1;
    endfunction

    function void check_result(sched_res_t act);
      sched_res_t exp;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $time, act);
        errors++;
        return;
      end
      exp = pending_res[0];
      pending_res.delete(0);
      if (act !== exp) begin
        $display("%0t: result mismatch expected %p actual %p", $time, exp, act);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_CREATE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sched_board board = new();
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         cycle_count = 0;
  // Slots reported as created, so random items usually address real tasks
  int         known_slots[$];

  always #6 clk_i = ~clk_i;

  task_dependency_scheduler_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // Accept and check results; stall at random
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sched_res_t r;
      r.rkind = m_axis_tuser;
      r.slot = m_axis_tdata[5:0];
      r.ok = m_axis_tdata[6];
      r.work = m_axis_tdata[7];
      r.notify = m_axis_tdata[8];
      r.last = m_axis_tlast;
      board.check_result(r);
      if (r.rkind == RES_CREATED && r.ok) known_slots.insert(known_slots.size(), int'(r.slot));
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Timeout guard
  always @(posedge clk_i) begin
    if (cycle_count > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Send one command, idling first at random
  task send_cmd(input logic [1:0] kind, input logic [23:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(kind, d);
  endtask

  function automatic int pick_slot();
    if (known_slots.size() > 0 && $urandom_range(9) < 8)
      return known_slots[$urandom_range(known_slots.size() - 1)];
    return $urandom_range(SLOTS - 1);
  endfunction

  // Build a create command; parents and dependencies are mostly drawn from slots reported as created
  function automatic logic [23:0] make_create(int pr, bit hp, bit hd);
    logic [23:0] d;
    d = 24'($urandom());
    d[7:6] = 2'(pr);
    d[8] = hp;
    d[14:9] = 6'(pick_slot());
    d[15] = hd;
    d[21:16] = 6'(pick_slot());
    return d;
  endfunction

  task random_cmd();
    logic [23:0] d;
    int r;
    d = 24'($urandom());
    d[5:0] = 6'(pick_slot());
    r = $urandom_range(99);
    if (r < 35) send_cmd(KIND_CREATE, make_create($urandom_range(3), 1'($urandom_range(1)),
                                                  1'($urandom_range(1))));
    else if (r < 60) send_cmd(KIND_DISPATCH, d);
    else if (r < 80) send_cmd(KIND_TAKE, d);
    else send_cmd(KIND_COMPLETE, d);
  endtask

  initial begin
    board.clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty take, bad dispatch and complete, extreme slots
    send_cmd(KIND_TAKE, 24'h000000);
    send_cmd(KIND_DISPATCH, 24'h00003f);
    send_cmd(KIND_COMPLETE, 24'h00003f);
    // Slots 0 and 1; slot 1 has priority 3, work and waiter set, and names free slot 63 as its dependency
    send_cmd(KIND_CREATE, 24'h000000);
    send_cmd(KIND_CREATE, 24'hff80c0 | (24'd0 << 9) | (24'd0 << 16) | 24'h3f);
    send_cmd(KIND_DISPATCH, 24'h000001);
    send_cmd(KIND_DISPATCH, 24'h000001);
    send_cmd(KIND_DISPATCH, 24'h000000);
    send_cmd(KIND_TAKE, 24'h000000);
    send_cmd(KIND_COMPLETE, 24'h000000);
    send_cmd(KIND_TAKE, 24'hffffff);
    send_cmd(KIND_COMPLETE, 24'h000001);
    send_cmd(KIND_COMPLETE, 24'h000001);
    // Fill the table, then hit the full case
    for (int i = 0; i < SLOTS + 1; i++)
      send_cmd(KIND_CREATE, make_create(i % 4, i > 0, 1'b0));

    // Random phases with different idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 28) : 0;
      recv_stall_pct = (ph == 2) ? 79 : (ph == 3 ? 28 : 0);
      for (int n = 0; n < 7; n++) begin
        // Once per phase: take a ready task and dispatch three picked slots
        if (n % 7 == 0) begin
          send_cmd(KIND_TAKE, 24'h0);
          for (int k = 0; k < 3; k++) send_cmd(KIND_DISPATCH, 24'(pick_slot()));
        end
        random_cmd();
      end
    end
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (board.pending_res.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/tds_pkg.sv
src/tds_ctrl.sv
src/tds_datapath.sv
src/task_dependency_scheduler_unit.sv
sim/testbench.sv
